/* src/buddy_page_allocator_defines.svh */
// ---------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ---------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BPA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* src/bpa_pkg.sv */
// ---------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the buddy page allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

   localparam int POOL_PAGES_DEF = 4096;
   localparam int TOP_ORDER_DEF  = 10;

   localparam int PAGE_W  = 12;
   localparam int ORDER_W = 4;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_RANGE  = 2'd1,
      STATUS_NOFREE = 2'd2
   } status_type;

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

endpackage

`default_nettype wire

/* src/buddy_page_allocator.sv */
// ---------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator with one linked free list per order, links in a RAM.
// ---------------------------------------------------------------------------
// One request at a time. An allocate scans up from the requested order
// over the empty lists, pops the head of the first non-empty one, splits
// it down one order per step and posts the result; an allocate that finds
// no block posts right after the scan. A free starts at its order, walks
// that list link by link (the link RAM has one registered read port),
// unlinks the buddy and moves up an order on each merge, then appends at
// the tail and posts the result. Out-of-range requests post directly. The
// next request is taken as soon as the result sits in the output register.
`default_nettype none

module buddy_page_allocator #(
   parameter int POOL_PAGES = bpa_pkg::POOL_PAGES_DEF,
   parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire logic                       req_mode,
   input  wire logic [bpa_pkg::ORDER_W-1:0] req_block_order,
   input  wire logic [bpa_pkg::PAGE_W-1:0]  req_block_page,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      logic [bpa_pkg::PAGE_W-1:0]  rsp_granted_page,
   output      logic [1:0]                 rsp_status
);
   import bpa_pkg::*;

   localparam int ADDR_W = $clog2(POOL_PAGES);
   localparam int PTR_W  = ADDR_W + 1;
   localparam int LVL_W  = (TOP_ORDER < 2) ? 1 : $clog2(TOP_ORDER + 1);
   localparam int STEP_W = $clog2(POOL_PAGES + 1);
   localparam int W1     = (PTR_W > TOP_ORDER + 1) ? PTR_W : TOP_ORDER + 1;
   localparam int W2     = (W1 > PAGE_W) ? W1 : PAGE_W;
   localparam int SUM_W  = W2 + 1;
   localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_PAGES);

   typedef enum logic [3:0] {
      ST_IDLE, ST_ALLOC_SCAN, ST_ALLOC_POP, ST_ALLOC_SPLIT,
      ST_FREE_START, ST_FREE_WALK, ST_FREE_NEXT, ST_FREE_UNLINK,
      ST_FREE_APPEND, ST_FREE_LINK, ST_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [PTR_W-1:0]         heads_ff [0:TOP_ORDER];
   logic [PTR_W-1:0]         heads_in [0:TOP_ORDER];
   logic [LVL_W-1:0]         ord_ff, ord_in, lvl_ff, lvl_in;
   logic [PTR_W-1:0]         page_ff, page_in, cur_ff, cur_in, prev_ff, prev_in;
   logic [STEP_W-1:0]        steps_ff, steps_in;
   logic [PAGE_W-1:0]        res_page_ff, res_page_in;
   status_type               res_status_ff, res_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0]        rsp_page_ff, rsp_page_in;
   status_type               rsp_status_ff, rsp_status_in;

   // link RAM
   logic [PTR_W-1:0]         link_mem [0:POOL_PAGES-1];
   logic [PTR_W-1:0]         mem_rdata_ff;
   logic [ADDR_W-1:0]        mem_raddr, mem_waddr;
   logic [PTR_W-1:0]         mem_wdata;
   logic                     mem_we;

   logic [SUM_W-1:0]         buddy, half, req_end;
   logic [LVL_W-1:0]         lvl_dn;
   logic                     can_merge;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= link_mem[mem_raddr];
   end

   assign buddy     = SUM_W'(page_ff) ^ (SUM_W'(1) << ord_ff);
   assign can_merge = ord_ff < LVL_W'(TOP_ORDER);
   assign lvl_dn    = lvl_ff - LVL_W'(1);
   assign half      = SUM_W'(cur_ff) + (SUM_W'(1) << lvl_dn);
   assign req_end   = SUM_W'(req_block_page) + (SUM_W'(1) << req_block_order);

   always_comb begin
      state_in      = state_ff;
      heads_in      = heads_ff;
      ord_in        = ord_ff;
      lvl_in        = lvl_ff;
      page_in       = page_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      res_page_in   = res_page_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      mem_raddr     = cur_ff[ADDR_W-1:0];
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_page_in   = '0;
               res_status_in = STATUS_OK;
               ord_in        = LVL_W'(req_block_order);
               lvl_in        = LVL_W'(req_block_order);
               page_in       = PTR_W'(req_block_page);
               if (32'(req_block_order) > TOP_ORDER) begin
                  res_status_in = STATUS_RANGE;
                  state_in      = ST_DONE;
               end else if (req_mode == MODE_ALLOC) begin
                  state_in = ST_ALLOC_SCAN;
               end else if (req_end > SUM_W'(POOL_PAGES)) begin
                  res_status_in = STATUS_RANGE;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_FREE_START;
               end
            end
         end
         ST_ALLOC_SCAN: begin
            if (heads_ff[lvl_ff] != NIL) begin
               cur_in    = heads_ff[lvl_ff];
               mem_raddr = heads_ff[lvl_ff][ADDR_W-1:0];
               state_in  = ST_ALLOC_POP;
            end else if (lvl_ff == LVL_W'(TOP_ORDER)) begin
               res_status_in = STATUS_NOFREE;
               state_in      = ST_DONE;
            end else begin
               lvl_in = lvl_ff + LVL_W'(1);
            end
         end
         ST_ALLOC_POP: begin
            heads_in[lvl_ff] = mem_rdata_ff;
            state_in         = ST_ALLOC_SPLIT;
         end
         ST_ALLOC_SPLIT: begin
            if (lvl_ff > ord_ff) begin
               lvl_in = lvl_dn;
               // upper half goes on the head of the next lower list
               if (half < SUM_W'(POOL_PAGES)) begin
                  mem_we           = 1'b1;
                  mem_waddr        = half[ADDR_W-1:0];
                  mem_wdata        = heads_ff[lvl_dn];
                  heads_in[lvl_dn] = half[PTR_W-1:0];
               end
            end else begin
               res_page_in = PAGE_W'(cur_ff);
               state_in    = ST_DONE;
            end
         end
         ST_FREE_START: begin
            cur_in   = heads_ff[ord_ff];
            prev_in  = NIL;
            steps_in = '0;
            state_in = ST_FREE_WALK;
         end
         ST_FREE_WALK: begin
            priority if (cur_ff == NIL) begin
               state_in = ST_FREE_APPEND;
            end else if (steps_ff == STEP_W'(POOL_PAGES)) begin
               state_in = ST_DONE;  // runaway list, drop
            end else if (cur_ff == page_ff) begin
               state_in = ST_DONE;  // double free
            end else if (can_merge && SUM_W'(cur_ff) == buddy) begin
               state_in = ST_FREE_UNLINK;
            end else begin
               prev_in  = cur_ff;
               steps_in = steps_ff + STEP_W'(1);
               state_in = ST_FREE_NEXT;
            end
         end
         ST_FREE_NEXT: begin
            cur_in   = mem_rdata_ff;
            state_in = ST_FREE_WALK;
         end
         ST_FREE_UNLINK: begin
            if (prev_ff == NIL) begin
               heads_in[ord_ff] = mem_rdata_ff;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = prev_ff[ADDR_W-1:0];
               mem_wdata = mem_rdata_ff;
            end
            if (buddy < SUM_W'(page_ff)) begin
               page_in = buddy[PTR_W-1:0];
            end
            ord_in   = ord_ff + LVL_W'(1);
            state_in = ST_FREE_START;
         end
         ST_FREE_APPEND: begin
            mem_we    = 1'b1;
            mem_waddr = page_ff[ADDR_W-1:0];
            mem_wdata = NIL;
            state_in  = ST_FREE_LINK;
         end
         ST_FREE_LINK: begin
            if (prev_ff == NIL) begin
               heads_in[ord_ff] = page_ff;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = prev_ff[ADDR_W-1:0];
               mem_wdata = page_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_page_in   = res_page_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= TOP_ORDER; i++) begin
            heads_ff[i] <= NIL;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         heads_ff     <= heads_in;
      end
      ord_ff        <= ord_in;
      lvl_ff        <= lvl_in;
      page_ff       <= page_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      res_page_ff   <= res_page_in;
      res_status_ff <= res_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_page = rsp_page_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

/* src/bpa_checker.sv */
// ---------------------------------------------------------------------------
// bpa_checker
// Port-level checks of the buddy page allocator, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "buddy_page_allocator_defines.svh"

module bpa_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [bpa_pkg::PAGE_W-1:0]  rsp_granted_page,
   input wire logic [1:0]                  rsp_status
);
   import bpa_pkg::*;

   // a held result stays put until its transfer
   `BPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_granted_page) && $stable(rsp_status))
   // after a request transfer the block is busy
   `BPA_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)
   // errors never grant a page
   `BPA_ASSERT_NOW(a_err_no_page, rsp_valid && rsp_status != STATUS_OK,
                   rsp_granted_page == '0)
   // no unused status code
   `BPA_ASSERT_NOW(a_status_code, rsp_valid,
                   rsp_status == STATUS_OK || rsp_status == STATUS_RANGE ||
                   rsp_status == STATUS_NOFREE)

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);

`default_nettype wire

/* sim/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the buddy page allocator. A predictor in the bench keeps its
// own free lists and computes the expected grant and status of every accepted
// request. The checker compares each response transfer with the oldest
// expectation. The run starts with directed cases, then random alloc/free
// traffic under three idling mixes and a long receiver hold-off.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bpa_pkg::*;

   localparam int NPAGES    = POOL_PAGES_DEF;
   localparam int LAST_ORDER = TOP_ORDER_DEF;
   localparam int NIL       = NPAGES;
   localparam int CYCLE_LIMIT = 40000000;

   typedef struct {
      logic [PAGE_W-1:0] page;
      status_type        status;
   } grant_type;

   typedef struct {
      int page;
      int order;
   } block_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_mode = 1'b0;
   logic [ORDER_W-1:0]  req_block_order = '0;
   logic [PAGE_W-1:0]   req_block_page = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [PAGE_W-1:0]   rsp_granted_page;
   logic [1:0]          rsp_status;

   grant_type  pending_grants[$];
   block_type  live_blocks[$];
   block_type  freed_blocks[$];
   int      free_heads[LAST_ORDER+1];
   int      free_links[NPAGES];
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_cycles = 0;
   int      cycle_count = 0;
   int      fail_count = 0;

   buddy_page_allocator i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_block_order (req_block_order),
      .req_block_page  (req_block_page),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_granted_page(rsp_granted_page),
      .rsp_status      (rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------- predictor ----------------
   function automatic int next_of(int p);
      return (p < NPAGES) ? free_links[p] : NIL;
   endfunction

   function automatic void link_to(int p, int v);
      if (p < NPAGES) free_links[p] = v;
   endfunction

   function automatic int take_block(int ord, output bit ok);
      int blk;
      int half;
      for (int lvl = ord; lvl <= LAST_ORDER; lvl++) begin
         blk = free_heads[lvl];
         if (blk != NIL) begin
            free_heads[lvl] = next_of(blk);
            while (lvl > ord) begin
               lvl--;
               half = blk + (1 << lvl);
               if (half < NPAGES) begin
                  free_links[half] = free_heads[lvl];
                  free_heads[lvl] = half;
               end
            end
            ok = 1'b1;
            return blk;
         end
      end
      ok = 1'b0;
      return 0;
   endfunction

   function automatic void release_block(int page, int ord);
      int buddy;
      int prev;
      int cur;
      int steps;
      bit merged;
      forever begin
         buddy = page ^ (1 << ord);
         prev = NIL;
         cur = free_heads[ord];
         steps = 0;
         merged = 1'b0;
         while (cur != NIL && steps < NPAGES) begin
            if (cur == page) return;
            if (ord < LAST_ORDER && cur == buddy) begin
               if (prev == NIL) free_heads[ord] = next_of(cur);
               else link_to(prev, next_of(cur));
               page = (page < buddy) ? page : buddy;
               ord++;
               merged = 1'b1;
               break;
            end
            prev = cur;
            cur = next_of(cur);
            steps++;
         end
         if (!merged) begin
            if (cur != NIL) return;
            link_to(page, NIL);
            if (prev == NIL) free_heads[ord] = page;
            else link_to(prev, page);
            return;
         end
      end
   endfunction

   function automatic grant_type predict_grant(mode_type mode, int ord, int page);
      grant_type g;
      bit ok;
      int blk;
      g.page = '0;
      g.status = STATUS_OK;
      if (ord > LAST_ORDER) begin
         g.status = STATUS_RANGE;
      end else if (mode == MODE_ALLOC) begin
         blk = take_block(ord, ok);
         if (ok) begin
            g.page = blk[PAGE_W-1:0];
            live_blocks.push_back('{blk, ord});
         end else begin
            g.status = STATUS_NOFREE;
         end
      end else if (page + (1 << ord) > NPAGES) begin
         g.status = STATUS_RANGE;
      end else begin
         release_block(page, ord);
         freed_blocks.push_back('{page, ord});
         if (freed_blocks.size() > 64) void'(freed_blocks.pop_front());
      end
      return g;
   endfunction

   // ---------------- stimulus ----------------
   task automatic send_request(mode_type mode, int ord, int page);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_block_order <= ord[ORDER_W-1:0];
      req_block_page <= page[PAGE_W-1:0];
      do @(posedge clock); while (req_stall);
      // predict on the field bits that the block actually sees
      pending_grants.push_back(predict_grant(mode, int'(ord[ORDER_W-1:0]),
                                             int'(page[PAGE_W-1:0])));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
   endtask

   task automatic free_live(int idx);
      block_type b;
      b = live_blocks[idx];
      live_blocks.delete(idx);
      send_request(MODE_FREE, b.order, b.page);
   endtask

   task automatic test_errors_on_empty();
      send_request(MODE_ALLOC, 0, 0);
      send_request(MODE_ALLOC, LAST_ORDER, 4095);
      send_request(MODE_ALLOC, 11, 0);
      send_request(MODE_FREE, 15, 0);
      send_request(MODE_FREE, 1, 4095);
      send_request(MODE_FREE, LAST_ORDER, 3584);
   endtask

   task automatic test_seed_pool();
      for (int p = 0; p < NPAGES; p += 1 << LAST_ORDER)
         send_request(MODE_FREE, LAST_ORDER, p);
   endtask

   task automatic test_split_and_merge();
      send_request(MODE_ALLOC, 0, 4095);
      for (int k = 0; k <= LAST_ORDER; k++) send_request(MODE_ALLOC, k, 0);
      // double free: second transfer must leave lists untouched
      send_request(MODE_FREE, LAST_ORDER, 0);
      send_request(MODE_FREE, LAST_ORDER, 0);
      while (live_blocks.size() != 0) free_live(live_blocks.size() - 1);
      // misaligned free, buddy still found by xor
      send_request(MODE_FREE, 1, 4093);
      wait_drained();
   endtask

   task automatic random_traffic(int count);
      int r;
      int ord;
      block_type b;
      repeat (count) begin
         r = $urandom_range(99);
         if (r < 4) begin
            send_request(mode_type'($urandom_range(1)), $urandom_range(11, 15),
                         $urandom_range(4095));
         end else if (r < 7 && freed_blocks.size() != 0) begin
            b = freed_blocks[$urandom_range(freed_blocks.size() - 1)];
            send_request(MODE_FREE, b.order, b.page);
         end else if (r < 9) begin
            ord = $urandom_range(LAST_ORDER);
            send_request(MODE_FREE, ord, NPAGES - ($urandom_range(1, 2) << ord) + 1);
         end else if (r < 55 && live_blocks.size() != 0) begin
            free_live($urandom_range(live_blocks.size() - 1));
         end else begin
            ord = ($urandom_range(9) == 0) ? $urandom_range(LAST_ORDER) : $urandom_range(3);
            send_request(MODE_ALLOC, ord, $urandom_range(4095));
         end
      end
   endtask

   task automatic test_idle_mixes();
      send_idle_pct = 22; recv_idle_pct = 73;
      random_traffic(650);
      send_idle_pct = 73; recv_idle_pct = 22;
      random_traffic(650);
      send_idle_pct = 0;  recv_idle_pct = 0;
      random_traffic(650);
   endtask

   task automatic test_backpressure();
      hold_cycles = 400;
      random_traffic(20);
      wait_drained();
   endtask

   // ---------------- receiver and checker ----------------
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected transfer, actual page %0d status %0d",
                     $realtime, rsp_granted_page, rsp_status);
            fail_count++;
         end else begin
            want = pending_grants.pop_front();
            if (rsp_granted_page !== want.page) begin
               $display("%0t: granted_page expected %0d actual %0d",
                        $realtime, want.page, rsp_granted_page);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $realtime, want.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k <= LAST_ORDER; k++) free_heads[k] = NIL;
      for (int p = 0; p < NPAGES; p++) free_links[p] = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_errors_on_empty();
      test_seed_pool();
      test_split_and_merge();
      test_backpressure();
      test_idle_mixes();
      wait_drained();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
